[design/ikba_pkg.sv]
// Package for the id-keyed bump allocator: sizes, payload and config structs,
// status and register codes. No dependencies.
package ikba_pkg;

   localparam int NUM_IDS    = 256;
   localparam int ID_BITS    = $clog2(NUM_IDS);
   localparam int COUNT_BITS = $clog2(NUM_IDS + 1);
   localparam int FIT_BITS   = 34;
   localparam int CSR_INDEX_BITS = 8;

   // Status codes of a result beat
   localparam logic [2:0] ST_NEW      = 3'd0;
   localparam logic [2:0] ST_FOUND    = 3'd1;
   localparam logic [2:0] ST_MISMATCH = 3'd2;
   localparam logic [2:0] ST_FULL     = 3'd3;
   localparam logic [2:0] ST_BAD_ID   = 3'd4;

   // Register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_POOL_BYTES       = 8'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HEADER_BYTES     = 8'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DESCRIPTOR_BYTES = 8'd2;

   typedef struct packed {
      logic [15:0] region_id;
      logic [31:0] region_bytes;
   } req_type;

   typedef struct packed {
      logic [31:0] region_offset;
      logic [2:0]  status;
   } rsp_type;

   typedef struct packed {
      logic [31:0] pool_bytes;
      logic [11:0] header_bytes;
      logic [7:0]  descriptor_bytes;
   } cfg_type;

   // One region record as kept in the region table
   typedef struct packed {
      logic [31:0] offset;
      logic [31:0] size;
   } entry_type;

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_EVAL = 2'b10
   } state_type;

endpackage

[design/ikba_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ikba_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[design/ikba_csr.sv]
// Configuration registers of the bump allocator.
// Depends on ikba_pkg.
module ikba_csr
   import ikba_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [31:0]               csr_data,
   output cfg_type                   cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_POOL_BYTES:       cfg_in.pool_bytes       = csr_data;
            CSR_HEADER_BYTES:     cfg_in.header_bytes     = csr_data[11:0];
            CSR_DESCRIPTOR_BYTES: cfg_in.descriptor_bytes = csr_data[7:0];
            default:              cfg_in = cfg_ff; // drop unknown index
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pool_bytes       <= 32'd65536;
         cfg_ff.header_bytes     <= 12'd16;
         cfg_ff.descriptor_bytes <= 8'd16;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

endmodule

[design/ikba_fit.sv]
// Capacity check: free pointer plus size plus reserved tail against the pool.
// Depends on ikba_pkg.
module ikba_fit
   import ikba_pkg::*;
(
   input  cfg_type               cfg,
   input  logic [31:0]           free_ptr,
   input  logic [COUNT_BITS-1:0] alloc_count,
   input  logic [31:0]           region_bytes,
   output logic                  fits
);

   logic [COUNT_BITS:0]     count_next;
   logic [COUNT_BITS+8:0]   desc_total;
   logic [FIT_BITS-1:0]     total;

   always_comb begin
      count_next = {1'b0, alloc_count} + (COUNT_BITS+1)'(1);
      desc_total = (COUNT_BITS+9)'(count_next) * (COUNT_BITS+9)'(cfg.descriptor_bytes);
      // Exact-width sum so an oversized reserve never wraps into a fit
      total = FIT_BITS'(free_ptr) + FIT_BITS'(region_bytes)
            + FIT_BITS'(cfg.header_bytes) + FIT_BITS'(desc_total);
      fits  = total < FIT_BITS'(cfg.pool_bytes);
   end

endmodule

[design/id_keyed_bump_allocator_top.sv]
// Id-keyed bump allocator, top level.
// Request channel (req_*): one beat carries region_id and region_bytes.
// Result channel (rsp_*): exactly one beat per request with region_offset
// and status (new, found, size mismatch, pool full, id out of range).
// Config channel (csr_*): always ready; index 0 pool_bytes, 1 header_bytes,
// 2 descriptor_bytes; other indexes are dropped. Write only while idle.
// Timing: a request is taken while idle and its region record is read from
// the region table RAM; the next cycle evaluates and writes the result into
// the output register once that register is free. A result beat follows its
// request through the state register and then the output register. A new
// request is taken only while idle, so the block evaluates one request at a
// time.
// Stall: the output register holds a result until rsp_ready; a second request
// may be taken meanwhile and waits in the evaluate step, state untouched.
// Reset: synchronous, active high; clears all id valid bits, the free pointer
// and the allocation count, and loads the config defaults (65536, 16, 16).
// Depends on ikba_pkg, ikba_ram, ikba_csr, ikba_fit.
module id_keyed_bump_allocator_top
   import ikba_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  req_type                   req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output rsp_type                   rsp_data,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [31:0]               csr_data
);

   cfg_type cfg;

   state_type state_ff, state_in;

   // Request held for the evaluate step
   logic [ID_BITS-1:0] id_ff, id_in;
   logic [31:0]        bytes_ff, bytes_in;
   logic               bad_id_ff, bad_id_in;

   // Allocator state
   logic [NUM_IDS-1:0]    id_valid_ff, id_valid_in;
   logic [31:0]           free_ptr_ff, free_ptr_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;

   // Output register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   logic      req_beat;
   logic      commit;
   logic      hit;
   logic      fits;
   logic      alloc;
   entry_type entry_rd;
   entry_type entry_wr;
   logic [63:0] entry_rd_bits;

   ikba_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // Region table: offset and size per id, read on the request beat
   ikba_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (NUM_IDS)
   ) u_table (
      .clock   (clock),
      .wr_en   (alloc),
      .wr_addr (id_ff),
      .wr_data (entry_wr),
      .rd_en   (req_beat),
      .rd_addr (req_data.region_id[ID_BITS-1:0]),
      .rd_data (entry_rd_bits)
   );

   ikba_fit u_fit (
      .cfg          (cfg),
      .free_ptr     (free_ptr_ff),
      .alloc_count  (count_ff),
      .region_bytes (bytes_ff),
      .fits         (fits)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign req_beat  = req_valid & req_ready;
   // Finish the evaluate step only when the output register can take it
   assign commit    = (state_ff == S_EVAL) & (~rsp_valid_ff | rsp_ready);
   assign entry_rd  = entry_type'(entry_rd_bits);
   assign hit       = id_valid_ff[id_ff];
   assign alloc     = commit & ~bad_id_ff & ~hit & fits;

   always_comb begin
      entry_wr.offset = free_ptr_ff;
      entry_wr.size   = bytes_ff;
   end

   always_comb begin
      state_in     = state_ff;
      id_in        = id_ff;
      bytes_in     = bytes_ff;
      bad_id_in    = bad_id_ff;
      id_valid_in  = id_valid_ff;
      free_ptr_in  = free_ptr_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      // Drop the result once the receiver takes it
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_beat) begin
               id_in     = req_data.region_id[ID_BITS-1:0];
               bytes_in  = req_data.region_bytes;
               bad_id_in = ({1'b0, req_data.region_id} >= 17'(NUM_IDS));
               state_in  = S_EVAL;
            end
         end
         S_EVAL: begin
            if (commit) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
               if (bad_id_ff) begin
                  rsp_data_in.region_offset = 32'd0;
                  rsp_data_in.status        = ST_BAD_ID;
               end else if (hit) begin
                  if (entry_rd.size == bytes_ff) begin
                     rsp_data_in.region_offset = entry_rd.offset;
                     rsp_data_in.status        = ST_FOUND;
                  end else begin
                     rsp_data_in.region_offset = 32'd0;
                     rsp_data_in.status        = ST_MISMATCH;
                  end
               end else if (!fits) begin
                  rsp_data_in.region_offset = 32'd0;
                  rsp_data_in.status        = ST_FULL;
               end else begin
                  // Hand out the old free pointer, then bump it
                  rsp_data_in.region_offset = free_ptr_ff;
                  rsp_data_in.status        = ST_NEW;
                  id_valid_in[id_ff]        = 1'b1;
                  free_ptr_in               = free_ptr_ff + bytes_ff;
                  count_in                  = count_ff + COUNT_BITS'(1);
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         id_valid_ff  <= '0;
         free_ptr_ff  <= 32'd0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         id_valid_ff  <= id_valid_in;
         free_ptr_ff  <= free_ptr_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers carry no reset
   always_ff @(posedge clock) begin
      id_ff       <= id_in;
      bytes_ff    <= bytes_in;
      bad_id_ff   <= bad_id_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
